// File: hdl/brf_pkg.sv
// brf_pkg: shared types and codes for the bus reply framer with timeout
// no dependencies; used by brf_len_check and bus_reply_framer_with_timeout
`default_nettype none

package brf_pkg;

  // item commands (in_tuser)
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_NO_REPLY = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT  = 2'd0;
  localparam logic [1:0] CFG_NORMAL = 2'd1;
  localparam logic [1:0] CFG_LONG   = 2'd2;

  localparam logic [15:0] SHORT_TICKS_RST  = 16'd4;
  localparam logic [15:0] NORMAL_TICKS_RST = 16'd100;
  localparam logic [15:0] LONG_TICKS_RST   = 16'd50000;

  // start flag bits
  localparam int FLAG_NO_REPLY = 1;
  localparam int FLAG_SHORT    = 2;
  localparam int FLAG_LONG     = 3;

  // protocol bytes
  localparam logic [7:0] ACK_CODE        = 8'h78;
  localparam logic [2:0] LEN_ESCAPE      = 3'h7;
  localparam logic [7:0] PING16_CODE     = 8'h1A;
  localparam logic [7:0] NODE16_CODE     = 8'h0A;
  localparam logic [7:0] READ_ERR_CODE   = 8'hA1;
  localparam logic [7:0] READ_RANGE_CODE = 8'hA2;

  typedef struct packed {
    logic        done;
    logic [15:0] len;
  } brf_check_t;

endpackage

`default_nettype wire

// File: hdl/brf_len_check.sv
// brf_len_check: decodes the announced reply length from the head bytes and
// flags a complete reply; depends on brf_pkg
`default_nettype none

module brf_len_check #(
  parameter int CNT_W = 11
) (
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [7:0]         head0,
  input  wire logic [7:0]         head1,
  input  wire logic [7:0]         head2,
  input  wire logic [7:0]         sent_first,
  input  wire logic [7:0]         sent_fifth,
  output brf_pkg::brf_check_t     check
);

  logic        cnt_is_one;
  logic        cnt_gt_one;
  logic        cnt_gt_two;
  logic        read_fail;
  logic        lone_ack;
  logic        is_ack;
  logic [2:0]  n_code;
  logic [8:0]  len_short;
  logic [15:0] len_long;
  logic [15:0] len;

  assign cnt_is_one = (count == CNT_W'(1));
  assign cnt_gt_one = (count > CNT_W'(1));
  assign cnt_gt_two = (count > CNT_W'(2));

  // read error replies, plain or behind a 16-bit node address
  assign read_fail =
      (sent_first == brf_pkg::READ_ERR_CODE) || (sent_first == brf_pkg::READ_RANGE_CODE) ||
      ((sent_first == brf_pkg::NODE16_CODE) &&
       ((sent_fifth == brf_pkg::READ_ERR_CODE) || (sent_fifth == brf_pkg::READ_RANGE_CODE)));

  assign lone_ack = cnt_is_one && (head0 == brf_pkg::ACK_CODE) &&
                    ((sent_first == brf_pkg::PING16_CODE) || read_fail);

  assign is_ack    = ((head0 & brf_pkg::ACK_CODE) == brf_pkg::ACK_CODE) &&
                     (count != '0);
  assign n_code    = head0[2:0];
  assign len_short = {1'b0, head1} + 9'd3;
  assign len_long  = {1'b0, head1[6:0], head2} + 16'd4;

  always_comb begin
    if (n_code != brf_pkg::LEN_ESCAPE) begin
      len = 16'(n_code) + 16'd2;
    end else if (!cnt_gt_one) begin
      len = 16'(n_code);
    end else if (len_short[7] && cnt_gt_two) begin
      len = len_long;
    end else begin
      len = 16'(len_short);
    end
  end

  always_comb begin
    check.done = 1'b0;
    check.len  = '0;
    if (lone_ack) begin
      check.done = 1'b1;
      check.len  = 16'd1;
    end else if (is_ack && ({1'b0, 16'(count)} == {1'b0, len})) begin
      check.done = 1'b1;
      check.len  = len;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bus_reply_framer_with_timeout.sv
// bus_reply_framer_with_timeout: top level of the reply framer
// depends on brf_pkg and brf_len_check
`default_nettype none

// Watches reply bytes after a command went out. A start transaction (tuser 0)
// arms the wait with the short, normal or long tick window, or reports "no
// reply expected" right away. Byte transactions (tuser 1) are counted up to
// RX_BUFFER_BYTES, the first three are kept to decode the announced length,
// and each counted byte restarts the window. Tick transactions (tuser 2) age
// the window and report a timeout when it runs out. Every input transaction
// gives exactly one result transaction. The block takes one transaction per
// clock while the result side keeps up: the input register feeds a single
// update of the counter, timer and length decode that writes the result
// register. The user must write window registers through the cfg port only
// while no transaction is in flight; the block itself does not enforce this.
module bus_reply_framer_with_timeout #(
  parameter int RX_BUFFER_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // flags, first_command_byte, fifth_command_byte, rx_data
  input  wire logic [1:0]  in_tuser,   // cmd
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // reply_length
  output logic [1:0]       out_tuser,  // status
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);

  // input register
  logic        in_valid_r;
  logic [1:0]  cmd_r;
  logic [7:0]  flags_r;
  logic [7:0]  first_r;
  logic [7:0]  fifth_r;
  logic [7:0]  rx_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [15:0] length_r;

  // window registers
  logic [15:0] short_ticks_r;
  logic [15:0] normal_ticks_r;
  logic [15:0] long_ticks_r;

  // framer state
  logic             waiting_r,  waiting_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic [15:0]      idle_r,     idle_nxt;
  logic [15:0]      limit_r,    limit_nxt;
  logic [7:0]       sent_first_r, sent_first_nxt;
  logic [7:0]       sent_fifth_r, sent_fifth_nxt;
  logic [7:0]       head_r [3];

  logic             advance;
  logic             process;
  logic             counted;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       head0_eff;
  logic [7:0]       head1_eff;
  logic [7:0]       head2_eff;
  logic [15:0]      idle_inc;
  logic [1:0]       res_status;
  logic [15:0]      res_length;
  brf_pkg::brf_check_t check;

  // pipeline moves when the result slot is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = length_r;
  assign out_tuser  = status_r;

  // a byte counts only while the buffer has room
  assign counted = (cmd_r == brf_pkg::CMD_BYTE) && (count_r < CNT_W'(RX_BUFFER_BYTES));

  // count as seen after this byte is stored
  assign count_inc = count_r + CNT_W'(1);

  // head bytes as seen after this byte is stored
  assign head0_eff = (counted && count_r == CNT_W'(0)) ? rx_r : head_r[0];
  assign head1_eff = (counted && count_r == CNT_W'(1)) ? rx_r : head_r[1];
  assign head2_eff = (counted && count_r == CNT_W'(2)) ? rx_r : head_r[2];

  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  brf_len_check #(
    .CNT_W (CNT_W)
  ) u_len_check (
    .count      (count_inc),
    .head0      (head0_eff),
    .head1      (head1_eff),
    .head2      (head2_eff),
    .sent_first (sent_first_r),
    .sent_fifth (sent_fifth_r),
    .check      (check)
  );

  // next state and result for the item in the input register
  always_comb begin
    waiting_nxt    = waiting_r;
    count_nxt      = count_r;
    idle_nxt       = idle_r;
    limit_nxt      = limit_r;
    sent_first_nxt = sent_first_r;
    sent_fifth_nxt = sent_fifth_r;
    res_status     = brf_pkg::ST_IDLE;
    res_length     = '0;
    case (cmd_r)
      brf_pkg::CMD_START: begin
        count_nxt      = '0;
        sent_first_nxt = first_r;
        sent_fifth_nxt = fifth_r;
        if (flags_r[brf_pkg::FLAG_NO_REPLY]) begin
          waiting_nxt = 1'b0;
          res_status  = brf_pkg::ST_NO_REPLY;
        end else begin
          // short flag wins over long
          if (flags_r[brf_pkg::FLAG_SHORT]) begin
            limit_nxt = short_ticks_r;
          end else if (flags_r[brf_pkg::FLAG_LONG]) begin
            limit_nxt = long_ticks_r;
          end else begin
            limit_nxt = normal_ticks_r;
          end
          idle_nxt    = '0;
          waiting_nxt = 1'b1;
        end
      end
      brf_pkg::CMD_BYTE: begin
        if (counted) begin
          count_nxt = count_inc;
          idle_nxt  = '0;
          if (waiting_r && check.done) begin
            res_status  = brf_pkg::ST_COMPLETE;
            res_length  = check.len;
            waiting_nxt = 1'b0;
          end
        end
      end
      brf_pkg::CMD_TICK: begin
        if (waiting_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= limit_r) begin
            res_status  = brf_pkg::ST_TIMEOUT;
            waiting_nxt = 1'b0;
          end
        end
      end
      default: begin
        // no operation
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      flags_r <= in_tdata[7:0];
      first_r <= in_tdata[15:8];
      fifth_r <= in_tdata[23:16];
      rx_r    <= in_tdata[31:24];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      status_r <= res_status;
      length_r <= res_length;
    end
  end

  // framer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r    <= 1'b0;
      count_r      <= '0;
      idle_r       <= '0;
      limit_r      <= '0;
      sent_first_r <= '0;
      sent_fifth_r <= '0;
    end else if (process) begin
      waiting_r    <= waiting_nxt;
      count_r      <= count_nxt;
      idle_r       <= idle_nxt;
      limit_r      <= limit_nxt;
      sent_first_r <= sent_first_nxt;
      sent_fifth_r <= sent_fifth_nxt;
    end
  end

  // head bytes, no reset: each is read only after being written
  always_ff @(posedge clk) begin
    if (process && counted) begin
      case (count_r)
        CNT_W'(0): head_r[0] <= rx_r;
        CNT_W'(1): head_r[1] <= rx_r;
        CNT_W'(2): head_r[2] <= rx_r;
        default: begin
        end
      endcase
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r  <= brf_pkg::SHORT_TICKS_RST;
      normal_ticks_r <= brf_pkg::NORMAL_TICKS_RST;
      long_ticks_r   <= brf_pkg::LONG_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        brf_pkg::CFG_SHORT:  short_ticks_r  <= cfg_wdata;
        brf_pkg::CFG_NORMAL: normal_ticks_r <= cfg_wdata;
        brf_pkg::CFG_LONG:   long_ticks_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // checks
  a_len_only_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && (status_r != brf_pkg::ST_COMPLETE) |-> (length_r == '0))
    else $error("nonzero length on a result that is not a completion");

  a_complete_has_len: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && (status_r == brf_pkg::ST_COMPLETE) |-> (length_r != '0))
    else $error("completion reported with zero length");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CNT_W'(RX_BUFFER_BYTES))
    else $error("received count beyond buffer size");

  a_end_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
      process && ((res_status == brf_pkg::ST_COMPLETE) || (res_status == brf_pkg::ST_TIMEOUT))
      |=> !waiting_r)
    else $error("wait still armed after completion or timeout");

  a_timeout_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
      process && (res_status == brf_pkg::ST_TIMEOUT) |-> waiting_r)
    else $error("timeout while not waiting");

endmodule

`default_nettype wire

// File: sim/bus_reply_framer_with_timeout_test.sv
// bus_reply_framer_with_timeout_test: self-checking testbench for the bus reply framer
// needs brf_pkg and the bus_reply_framer_with_timeout rtl; reads no files
`timescale 1ns / 100ps

module bus_reply_framer_with_timeout_test;

  // buffer size the block is built with, kept in step with the predictor
  localparam int BUF_BYTES = 1024;
  // no-operation command, not named in the package
  localparam logic [1:0] CMD_NOP = 2'd3;
  // generous ceiling, many times the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] flags;
    logic [7:0] first;
    logic [7:0] fifth;
    logic [7:0] rx;
  } bus_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] len;
  } reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // flags, first_command_byte, fifth_command_byte, rx_data
  logic [1:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // reply_length
  logic [1:0]  out_tuser;       // status
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  bus_reply_framer_with_timeout #(
    .RX_BUFFER_BYTES(BUF_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // items waiting to be driven and replies waiting to come back
  bus_item_t bus_items[$];
  reply_t    pending_replies[$];
  bus_item_t next_item;
  reply_t    want;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 80;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predictor copy of the window registers and the framer state
  logic [15:0] win_short = brf_pkg::SHORT_TICKS_RST;
  logic [15:0] win_normal = brf_pkg::NORMAL_TICKS_RST;
  logic [15:0] win_long = brf_pkg::LONG_TICKS_RST;
  bit          awaiting = 1'b0;
  int unsigned rx_count = 0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] win_limit = '0;
  logic [7:0]  head_bytes[3];
  logic [7:0]  sent_first = '0;
  logic [7:0]  sent_fifth = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random byte
  function automatic logic [7:0] rand8();
    return 8'($urandom_range(255));
  endfunction

  // advance the framer by one accepted transaction and return its reply
  function automatic reply_t framer_step(input logic [1:0] cmd, input logic [31:0] data);
    reply_t      r;
    logic [7:0]  flags;
    logic [7:0]  rx;
    int unsigned n;
    bit          read_fail;
    r.status = brf_pkg::ST_IDLE;
    r.len = '0;
    flags = data[7:0];
    rx = data[31:24];
    case (cmd)
      brf_pkg::CMD_START: begin
        rx_count = 0;
        sent_first = data[15:8];
        sent_fifth = data[23:16];
        if (flags[brf_pkg::FLAG_NO_REPLY]) begin
          awaiting = 1'b0;
          r.status = brf_pkg::ST_NO_REPLY;
        end else begin
          // short window wins over long when both flags are set
          if (flags[brf_pkg::FLAG_SHORT])
            win_limit = win_short;
          else if (flags[brf_pkg::FLAG_LONG])
            win_limit = win_long;
          else
            win_limit = win_normal;
          idle_ticks = '0;
          awaiting = 1'b1;
        end
      end
      brf_pkg::CMD_BYTE: begin
        // bytes past a full buffer are dropped and do not restart the window
        if (rx_count < BUF_BYTES) begin
          if (rx_count < 3)
            head_bytes[rx_count[1:0]] = rx;
          rx_count++;
          idle_ticks = '0;
          if (awaiting) begin
            read_fail =
                (sent_first inside {brf_pkg::READ_ERR_CODE, brf_pkg::READ_RANGE_CODE}) ||
                (sent_first == brf_pkg::NODE16_CODE &&
                 sent_fifth inside {brf_pkg::READ_ERR_CODE, brf_pkg::READ_RANGE_CODE});
            n = 0;
            if (rx_count == 1 && head_bytes[0] == brf_pkg::ACK_CODE &&
                (sent_first == brf_pkg::PING16_CODE || read_fail)) begin
              // lone ack closes a ping or a read error reply
              n = 1;
            end else if ((head_bytes[0] & brf_pkg::ACK_CODE) == brf_pkg::ACK_CODE) begin
              n = 32'(head_bytes[0][2:0]);
              if (n == 32'(brf_pkg::LEN_ESCAPE)) begin
                // variable length: one length byte, or two when its sum has bit 7
                if (rx_count > 1) begin
                  n = head_bytes[1] + 3;
                  if (n[7] && rx_count > 2)
                    n = {head_bytes[1][6:0], head_bytes[2]} + 4;
                end
              end else begin
                n = n + 2;
              end
              if (rx_count != n)
                n = 0;
            end
            if (n != 0) begin
              r.status = brf_pkg::ST_COMPLETE;
              r.len = n[15:0];
              awaiting = 1'b0;
            end
          end
        end
      end
      brf_pkg::CMD_TICK: begin
        if (awaiting) begin
          if (idle_ticks != 16'hFFFF)
            idle_ticks++;
          if (idle_ticks >= win_limit) begin
            r.status = brf_pkg::ST_TIMEOUT;
            awaiting = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_item(input logic [1:0] c, input logic [7:0] f, a, e, d);
    bus_item_t it;
    it.cmd = c;
    it.flags = f;
    it.first = a;
    it.fifth = e;
    it.rx = d;
    bus_items.push_back(it);
  endfunction

  // one start, the reply bytes behind it (whole, cut short or overlong),
  // stray ticks and no-ops in between, then ticks toward a timeout
  function automatic void queue_reply_exchange();
    logic [7:0]  f;
    logic [7:0]  a;
    logic [7:0]  e;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    int unsigned lim;
    int unsigned nbytes;
    int unsigned i;
    f = rand8();
    f[brf_pkg::FLAG_NO_REPLY] = ($urandom_range(9) == 0);
    case ($urandom_range(5))
      0: a = brf_pkg::PING16_CODE;
      1: a = brf_pkg::READ_ERR_CODE;
      2: a = brf_pkg::READ_RANGE_CODE;
      3: a = brf_pkg::NODE16_CODE;
      default: a = rand8();
    endcase
    if ($urandom_range(1))
      e = $urandom_range(1) ? brf_pkg::READ_ERR_CODE : brf_pkg::READ_RANGE_CODE;
    else
      e = rand8();
    add_item(brf_pkg::CMD_START, f, a, e, rand8());
    lim = 32'(f[brf_pkg::FLAG_SHORT] ? win_short
              : (f[brf_pkg::FLAG_LONG] ? win_long : win_normal));

    b0 = rand8();
    b1 = rand8();
    b2 = rand8();
    case ($urandom_range(9))
      0: begin
        b0 = brf_pkg::ACK_CODE;
        nbytes = 1;
      end
      1, 2, 3: begin
        // plain ack, length in the low bits
        b0[6:3] = 4'hF;
        b0[2:0] = 3'($urandom_range(6));
        nbytes = b0[2:0] + 2;
      end
      4, 5: begin
        // one length byte
        b0[6:0] = 7'h7F;
        if ($urandom_range(5) == 0)
          b1 = 8'($urandom_range(8'hFF, 8'hFD));
        else if ($urandom_range(3) == 0)
          b1 = 8'($urandom_range(8'h7C));
        else
          b1 = 8'($urandom_range(30));
        nbytes = b1 + 3;
      end
      6, 7: begin
        // two length bytes, kept mostly short
        b0[6:0] = 7'h7F;
        b1 = ($urandom_range(7) == 0) ? 8'h81 : 8'h80;
        b2 = $urandom_range(1) ? 8'($urandom_range(20)) : rand8();
        nbytes = {b1[6:0], b2} + 4;
      end
      8: begin
        // arbitrary first byte, usually not an ack
        nbytes = $urandom_range(8, 1);
      end
      default: begin
        // announced length beyond the buffer, never completes
        b0[6:0] = 7'h7F;
        b1 = $urandom_range(1) ? 8'($urandom_range(8'h7F, 8'h7D))
                               : 8'($urandom_range(8'hFC, 8'h84));
        nbytes = $urandom_range(12, 3);
      end
    endcase
    if ($urandom_range(5) == 0 && nbytes > 1)
      nbytes = $urandom_range(nbytes - 1, 1);
    else if ($urandom_range(5) == 0)
      nbytes += $urandom_range(3, 1);

    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(15) == 0)
        add_item(brf_pkg::CMD_TICK, rand8(), rand8(), rand8(), rand8());
      if ($urandom_range(29) == 0)
        add_item(CMD_NOP, rand8(), rand8(), rand8(), rand8());
      add_item(brf_pkg::CMD_BYTE, rand8(), rand8(), rand8(),
               (i == 0) ? b0 : (i == 1) ? b1 : (i == 2) ? b2 : rand8());
    end
    repeat ($urandom_range((lim < 40) ? lim + 1 : 40, 0))
      add_item(brf_pkg::CMD_TICK, rand8(), rand8(), rand8(), rand8());
    // noise while idle or still waiting
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(3, 1))
        add_item(2'($urandom_range(3, 1)), rand8(), rand8(), rand8(), rand8());
  endfunction

  // everything driven and every reply back, then let the pipeline drain
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (bus_items.size() != 0 || in_tvalid || pending_replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // program all three windows while nothing is in flight
  task automatic set_windows(input logic [15:0] s, n, l);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= brf_pkg::CFG_SHORT;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_addr <= brf_pkg::CFG_NORMAL;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_addr <= brf_pkg::CFG_LONG;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_short = s;
    win_normal = n;
    win_long = l;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] s, n, l, input int unsigned snd, rcv,
                           input bit full_buffer);
    int unsigned base;
    int unsigned i;
    set_windows(s, n, l);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    if (full_buffer) begin
      // normal window, oversized length, then fill the buffer; dropped bytes
      // between ticks must not restart the window
      add_item(brf_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
      add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF);
      add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h7F);
      add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF);
      for (i = 3; i < BUF_BYTES; i++)
        add_item(brf_pkg::CMD_BYTE, rand8(), rand8(), rand8(), rand8());
      repeat (3) begin
        add_item(brf_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, rand8());
      end
    end
    base = bus_items.size();
    while (bus_items.size() - base < 140)
      queue_reply_exchange();
    wait_for_quiet();
  endtask

  // sender: holds each transaction until accepted, predicts its reply on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        pending_replies.push_back(framer_step(in_tuser, in_tdata));
      if (!in_tvalid || in_tready) begin
        if (bus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = bus_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_item.cmd;
          in_tdata <= {next_item.rx, next_item.fifth, next_item.first, next_item.flags};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure, each accepted reply checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected reply: status %0d length %0d", out_tuser, out_tdata);
        end else begin
          want = pending_replies.pop_front();
          if (out_tuser !== want.status || out_tdata !== want.len) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("reply mismatch: expected status %0d length %0d, got status %0d length %0d",
                       want.status, want.len, out_tuser, out_tdata);
          end
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on the reset windows (short 4, normal 100, long 50000)
    add_item(brf_pkg::CMD_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);    // byte while idle
    add_item(brf_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);    // tick while idle
    add_item(CMD_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);              // no-op
    add_item(brf_pkg::CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // no reply expected
    add_item(brf_pkg::CMD_START, 8'h04, brf_pkg::PING16_CODE, 8'h00, 8'h00); // ping, short
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, brf_pkg::ACK_CODE);     // lone ack
    add_item(brf_pkg::CMD_START, 8'h00, brf_pkg::NODE16_CODE, brf_pkg::READ_RANGE_CODE,
             8'h00);
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, brf_pkg::ACK_CODE); // node read range
    add_item(brf_pkg::CMD_START, 8'h04, 8'h00, 8'h00, 8'h00);
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF);    // escape length
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h7D);    // two-byte form
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);    // oversized length
    repeat (4)
      add_item(brf_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);  // times out on the fourth
    add_item(brf_pkg::CMD_START, 8'h0C, brf_pkg::READ_ERR_CODE, 8'h00, 8'h00); // short wins
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h79);    // ack, length 3
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_item(brf_pkg::CMD_START, 8'h08, brf_pkg::NODE16_CODE, 8'h00, 8'h00); // long window
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, brf_pkg::ACK_CODE); // not lone-ack cmd
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h55);    // completes at length 2
    add_item(brf_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hAA);    // after completion
    add_item(brf_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_for_quiet();

    // random phases: receiver idles more first, then the sender, then neither
    run_phase(16'd1, 16'd3, 16'd7, 35, 80, 1'b1);
    run_phase(16'd0, 16'd12, 16'd65535, 35, 80, 1'b0);
    run_phase(16'd65535, 16'd1, 16'd2, 80, 35, 1'b0);
    run_phase(16'd3, 16'd65535, 16'd1, 80, 35, 1'b0);
    run_phase(16'd6, 16'd25, 16'd10, 0, 0, 1'b0);

    if (fail_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
